// ----- rtl/sha_pkg.sv -----
// Package for the SHA-256 stream hasher: payload types, constants and a rotate function.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       write_byte;   // store a byte at the write pointer
        logic [7:0] wr_data;
        logic       pad_byte;     // store a padding byte at the write pointer
        logic       len_byte;     // store the next byte of the bit length
        logic       start_block;  // load working variables and begin rounds
        logic       init_hash;    // restore initial hash values
        logic       shift_digest; // move the next digest word forward
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic [6:0] fill;
    } t_status;

    localparam int BLOCK_BYTES = 64;
    localparam int LENGTH_POS  = 56;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- rtl/sha_datapath.sv -----
// Datapath of the SHA-256 hasher: block buffer, message schedule, round unit and hash state.
module sha_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_pkg::t_cmd       i_cmd,
    output sha_pkg::t_status    o_status,
    output logic [31:0]         o_digest
);

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [6:0]  r_fill;
    logic [6:0]  r_round;
    logic        r_busy;
    logic [60:0] r_count;

    logic [31:0] sched_w, s0, s1, w_next, t1, t2, big1, big0, ch, maj;
    logic [31:0] w_ins;
    logic [7:0]  wbyte;
    logic [63:0] bits;
    logic [63:0] len_shifted;
    logic [3:0]  widx;

    assign bits        = {r_count, 3'b000};
    assign len_shifted = bits << {r_fill[2:0], 3'b000};
    assign widx        = r_fill[5:2];
    assign wbyte       = i_cmd.len_byte ? len_shifted[63:56] : i_cmd.wr_data;

    always_comb begin
        w_ins = r_w[widx];
        case (r_fill[1:0])
            2'd0: w_ins[31:24] = wbyte;
            2'd1: w_ins[23:16] = wbyte;
            2'd2: w_ins[15:8]  = wbyte;
            default: w_ins[7:0] = wbyte;
        endcase
    end

    assign sched_w = r_w[0];
    assign s0 = sha_pkg::ror(r_w[1], 7) ^ sha_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = sha_pkg::ror(r_w[14], 17) ^ sha_pkg::ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_next = s1 + r_w[9] + s0 + r_w[0];
    assign big1 = sha_pkg::ror(r_v[4], 6) ^ sha_pkg::ror(r_v[4], 11) ^ sha_pkg::ror(r_v[4], 25);
    assign ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + big1 + ch + sha_pkg::ROUND_K[r_round[5:0]] + sched_w;
    assign big0 = sha_pkg::ror(r_v[0], 2) ^ sha_pkg::ror(r_v[0], 13) ^ sha_pkg::ror(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = big0 + maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fill  <= '0;
            r_round <= '0;
            r_count <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_H[i];
        end else begin
            if (i_cmd.write_byte || i_cmd.pad_byte || i_cmd.len_byte) begin
                r_w[widx] <= w_ins;
                r_fill    <= r_fill + 7'd1;
                if (i_cmd.write_byte) r_count <= r_count + 61'd1;
            end
            if (i_cmd.start_block) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            if (r_busy) begin
                // One round per cycle; the schedule window shifts along with it.
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_next;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 7'd1;
                if (r_round == 7'd63) begin
                    r_busy <= 1'b0;
                    r_fill <= '0;
                end
            end
            if (r_round == 7'd64 && !r_busy) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_round <= '0;
            end
            if (i_cmd.shift_digest) begin
                for (int i = 0; i < 7; i++) r_h[i] <= r_h[i + 1];
                r_h[7] <= r_h[0];
            end
            if (i_cmd.init_hash) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_H[i];
                r_count <= '0;
                r_fill  <= '0;
            end
        end
    end

    assign o_status.busy = r_busy || (r_round == 7'd64);
    assign o_status.fill = r_fill;
    assign o_digest      = r_h[0];

endmodule

// ----- rtl/sha_controller.sv -----
// Controller of the SHA-256 hasher: input acceptance, padding sequence and digest output.
module sha_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sha_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_index,
    output sha_pkg::t_cmd        o_cmd,
    input  sha_pkg::t_status     i_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_idx, n_idx;
    logic       r_end, n_end;
    logic       r_final, n_final;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_end   = r_end;
        n_final = r_final;
        o_cmd   = '0;
        o_cmd.wr_data = i_data.data_byte;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = i_status.busy;
                if (!i_status.busy && i_valid) begin
                    o_cmd.write_byte = i_data.has_byte;
                    n_end   = i_data.end_of_message;
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (!i_status.busy) begin
                    if (i_status.fill == 7'(sha_pkg::BLOCK_BYTES)) begin
                        o_cmd.start_block = 1'b1;
                    end else if (r_end) begin
                        n_state = S_MARK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MARK: begin
                // The 0x80 marker goes in as a byte that is not counted.
                o_cmd.pad_byte = 1'b1;
                o_cmd.wr_data  = 8'h80;
                o_cmd.write_byte = 1'b0;
                n_final = (i_status.fill < 7'(sha_pkg::LENGTH_POS));
                n_state = S_PAD;
            end
            S_PAD: begin
                if (!i_status.busy) begin
                    if (i_status.fill == 7'(sha_pkg::BLOCK_BYTES)) begin
                        o_cmd.start_block = 1'b1;
                        if (r_final) n_state = S_OUT;
                        n_final = 1'b1;
                    end else if (r_final && i_status.fill >= 7'(sha_pkg::LENGTH_POS)) begin
                        // The last eight bytes of the final block carry the bit length.
                        o_cmd.len_byte = 1'b1;
                    end else begin
                        o_cmd.pad_byte = 1'b1;
                        o_cmd.wr_data  = 8'h00;
                    end
                end
            end
            S_OUT: begin
                if (!i_status.busy && !i_stall) begin
                    o_cmd.shift_digest = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.shift_digest = 1'b0;
                        o_cmd.init_hash    = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_end   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_end   <= n_end;
            r_final <= n_final;
        end
    end

    assign o_valid = (r_state == S_OUT) && !i_status.busy;
    assign o_index = r_idx;

endmodule

// ----- rtl/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher.
// A byte transaction passes through the idle and byte states; a byte that fills a block adds a
// start, 64 rounds and the feed-forward add. End of message adds a marker write, padding
// writes and one or two blocks, then eight digest
// transactions, one per cycle when the sink is not stalling.
// Reset is synchronous and active low; it restores the initial hash value and empties the buffer.
module sha256_stream_hasher (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  sha_pkg::t_in_item      i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output sha_pkg::t_out_item     o_data
);

    sha_pkg::t_cmd    cmd;
    sha_pkg::t_status status;
    logic [31:0]      digest;
    logic [2:0]       index;

    // The controller sequences input bytes, padding and the digest transactions.
    sha_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_index  (index),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // The datapath holds the buffer, schedule window, round registers and chaining value.
    sha_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .o_digest (digest)
    );

    assign o_data.digest_word = digest;
    assign o_data.word_index  = index;
    assign o_data.last        = (index == 3'd7);

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the SHA-256 stream hasher: byte stimulus, digest prediction and checking.
`timescale 1ns / 1ps

module tb_top;

    // Scoreboard: it hashes the accepted bytes itself and keeps a queue of expected digest words.
    class digest_scoreboard;
        logic [31:0] hash_state [8];
        logic [7:0]  msg_block [64];
        int unsigned block_fill;
        logic [60:0] byte_total;
        sha_pkg::t_out_item pending_words [$];
        int unsigned error_count;
        int unsigned digests_seen;

        function new();
            error_count = 0;
            digests_seen = 0;
            foreach (msg_block[i]) msg_block[i] = 8'h00;
            restart_message();
        endfunction

        function void restart_message();
            foreach (hash_state[i]) hash_state[i] = sha_pkg::INIT_H[i];
            block_fill = 0;
            byte_total = '0;
        endfunction

        function logic [31:0] rot(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void run_compression();
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
                                        hash_state[3], hash_state[4], hash_state[5],
                                        hash_state[6], hash_state[7]};
            for (int i = 0; i < 64; i++) begin
                t1 = h + (rot(e, 6) ^ rot(e, 11) ^ rot(e, 25)) + ((e & f) ^ (~e & g))
                   + sha_pkg::ROUND_K[i] + w[i];
                t2 = (rot(a, 2) ^ rot(a, 13) ^ rot(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
            hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
        endfunction

        // Note one accepted input transaction and queue any digest words it produces.
        function void note_input(sha_pkg::t_in_item item);
            logic [63:0]        bit_len;
            sha_pkg::t_out_item word;
            if (item.has_byte) begin
                msg_block[block_fill] = item.data_byte;
                block_fill++;
                byte_total++;
                if (block_fill == 64) begin
                    run_compression();
                    block_fill = 0;
                end
            end
            if (!item.end_of_message) return;
            bit_len = {byte_total, 3'b000};
            msg_block[block_fill] = 8'h80;
            block_fill++;
            if (block_fill > sha_pkg::LENGTH_POS) begin
                for (int i = block_fill; i < 64; i++) msg_block[i] = 8'h00;
                run_compression();
                block_fill = 0;
            end
            for (int i = block_fill; i < sha_pkg::LENGTH_POS; i++) msg_block[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                msg_block[sha_pkg::LENGTH_POS + i] = bit_len[63 - 8*i -: 8];
            run_compression();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_state[i];
                word.word_index  = 3'(i);
                word.last        = (i == 7);
                pending_words.push_back(word);
            end
            restart_message();
        endfunction

        // Compare one accepted output transaction with the oldest expected digest word.
        function void check_word(sha_pkg::t_out_item got);
            sha_pkg::t_out_item want;
            if (pending_words.size() == 0) begin
                $error("unexpected digest word %h", got.digest_word);
                error_count++;
                return;
            end
            want = pending_words.pop_front();
            if (got.digest_word !== want.digest_word) begin
                $error("digest_word expected %h actual %h", want.digest_word, got.digest_word);
                error_count++;
            end
            if (got.word_index !== want.word_index) begin
                $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
                error_count++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0b actual %0b", want.last, got.last);
                error_count++;
            end
            if (got.last === 1'b1) digests_seen++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    sha_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_stall;
    sha_pkg::t_out_item o_data;

    digest_scoreboard sb = new();
    int unsigned      items_sent = 0;
    bit               sink_hold = 0;   // forces a long stall on the digest side
    bit               stimulus_done = 0;

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, with the occasional long one.
    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one input transaction and hold it until the hasher accepts it.
    // Valid stays high into the next item when there is no gap.
    task automatic send_item(logic [7:0] b, logic has, logic eom);
        int unsigned gap;
        gap = gap_length();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, has_byte: has, end_of_message: eom};
        do @(posedge i_clk); while (o_stall);
        sb.note_input(i_data);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned len, bit empty_end);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_end);
        if (empty_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Withdraw the input and wait until every expected digest word has been seen.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_words.size() != 0);
    endtask

    // Sink side: random stalls, overridden by the long hold-off when requested.
    always @(negedge i_clk) begin
        if (sink_hold) i_stall <= 1'b1;
        else if ($urandom_range(0, 3) != 0) i_stall <= 1'b0;
        else i_stall <= (gap_length() != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_word(o_data);
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty message, byte extremes, items without a byte, end with a byte.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'ha5, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b0, 1'b1);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'hfe, 1'b1, 1'b1);
        wait_drained();

        // Padding that no longer fits and spills into an extra block.
        send_message(60, 0);

        // Long receiver hold-off while the sender keeps offering complete messages.
        fork
            begin
                sink_hold = 1'b1;
                repeat (600) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                send_message(3, 0);
                send_message(0, 1);
                send_message(5, 1);
                wait_drained();
            end
        join

        // Random part: short messages and some idle noise items.
        while (items_sent < 100) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else
                send_message($urandom_range(0, 12), $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        wait_drained();
        repeat (200) @(negedge i_clk);
        stimulus_done = 1'b1;

        $display("Drove %0d input transactions and checked %0d digests.",
                 items_sent, sb.digests_seen);
        $display("Empty messages, padding into an extra block and a long sink stall were included.");
        if (sb.error_count == 0 && sb.pending_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #2000000;
        $display("Timed out after %0d transactions", items_sent);
        $display("Mismatches found");
        $finish;
    end

endmodule
